// ===== rtl/rla_pkg.sv =====
// Shared constants, types and helper functions of the receive line assembler.
`default_nettype none

package rla_pkg;

  localparam int CHAR_DEPTH = 32;
  localparam int LINE_SLOTS = 8;
  localparam int BYTE_W     = 8;
  localparam int CHAR_AW    = $clog2(CHAR_DEPTH);
  localparam int LINE_AW    = $clog2(LINE_SLOTS);
  localparam int LS_DEPTH   = LINE_SLOTS * CHAR_DEPTH;
  localparam int LS_AW      = $clog2(LS_DEPTH);

  localparam logic OP_RX_BYTE   = 1'b0;
  localparam logic OP_READ_LINE = 1'b1;

  localparam logic [BYTE_W-1:0] BYTE_NUL = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_DEL = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_LF  = 8'h0A;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE,
    ST_READ
  } rla_state_e;

  // Ring position advance with wrap at the ring depth.
  function automatic logic [CHAR_AW-1:0] char_next(input logic [CHAR_AW-1:0] p);
    return (p == CHAR_AW'(CHAR_DEPTH - 1)) ? '0 : CHAR_AW'(p + CHAR_AW'(1));
  endfunction

  function automatic logic [LINE_AW-1:0] line_next(input logic [LINE_AW-1:0] p);
    return (p == LINE_AW'(LINE_SLOTS - 1)) ? '0 : LINE_AW'(p + LINE_AW'(1));
  endfunction

  // Flat address of character n of line slot s.
  function automatic logic [LS_AW-1:0] ls_addr(input logic [LINE_AW-1:0] s,
                                               input logic [CHAR_AW-1:0] n);
    return LS_AW'(LS_AW'(s) * LS_AW'(CHAR_DEPTH) + LS_AW'(n));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rla_stream_if.sv =====
// Valid/ready stream interfaces for the input and result channels.
`default_nettype none

interface rla_in_if import rla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, opcode, rx_byte, input ready);
  modport sink   (input valid, opcode, rx_byte, output ready);
endinterface

interface rla_out_if import rla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] line_char;
  logic              no_line;
  logic              last;

  modport source (output valid, line_char, no_line, last, input ready);
  modport sink   (input valid, line_char, no_line, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/rx_line_assembler_fifo.sv =====
// Top level: receive line assembler with a character ring and a ring of line slots.
`default_nettype none

// Channel  Dir  Payload                      Handshake
// in_i     in   opcode, rx_byte              valid/ready, word taken when both high
// out_o    out  line_char, no_line, last     valid/ready, word taken when both high
//
// A received byte is taken while the block is idle and its result register is free. An end of
// line that stores pending characters keeps the input busy until they are moved: the ring has
// one registered read port, so characters walk one per cycle into the line store, after which
// the slot is closed. A read request returns one character per cycle while the sink takes
// every word; a stall on out_o holds the walk.
// Reset clears all pointers and the sequencer; the stores need no clearing.

module rx_line_assembler_fifo import rla_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  rla_in_if.sink    in_i,
  rla_out_if.source out_o
);

  rla_state_e state_q, state_d;

  logic [CHAR_AW-1:0] char_head_q, char_head_d;
  logic [CHAR_AW-1:0] char_tail_q, char_tail_d;
  logic [LINE_AW-1:0] line_head_q, line_head_d;
  logic [LINE_AW-1:0] line_tail_q, line_tail_d;
  logic [CHAR_AW-1:0] line_length_q [LINE_SLOTS];

  // Working registers of the sequencer: the slot in use, the character count
  // (walk index) and, for a read, the length of the line being returned.
  logic [LINE_AW-1:0] slot_q, slot_d;
  logic [CHAR_AW-1:0] cnt_q, cnt_d;
  logic [CHAR_AW-1:0] len_q, len_d;

  // Move pipeline: a ring read issued in one cycle is written to the line
  // store in the next.
  logic               mv_v_q, mv_v_d;
  logic [CHAR_AW-1:0] mv_idx_q, mv_idx_d;

  // Character ring memory.
  logic [BYTE_W-1:0]  char_ring [CHAR_DEPTH];
  logic               ring_we, ring_re;
  logic [CHAR_AW-1:0] ring_wa, ring_ra;
  logic [BYTE_W-1:0]  ring_rd_q;

  // Line store memory.
  logic [BYTE_W-1:0]  line_store [LS_DEPTH];
  logic               ls_we, ls_re;
  logic [LS_AW-1:0]   ls_wa, ls_ra;
  logic [BYTE_W-1:0]  ls_rd_q;

  logic               len_we;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]  out_char_q, out_char_d;
  logic               out_no_line_q, out_no_line_d;
  logic               out_last_q, out_last_d;
  logic               out_load;
  logic               out_free;

  // Decode of the current word and sequencer conditions.
  logic               accept;
  logic               is_drop, is_eol;
  logic               ring_empty, lines_full, lines_empty;
  logic               start_move, start_read;
  logic               move_done, read_last, read_done;
  logic [LINE_AW-1:0] new_slot, rd_slot;

  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == ST_IDLE) && out_free;
  assign accept      = in_i.valid && in_i.ready;

  assign is_drop     = in_i.rx_byte inside {BYTE_NUL, BYTE_DEL};
  assign is_eol      = in_i.rx_byte inside {BYTE_CR, BYTE_LF};
  assign ring_empty  = (char_head_q == char_tail_q);
  assign new_slot    = line_next(line_head_q);
  assign rd_slot     = line_next(line_tail_q);
  assign lines_full  = (new_slot == line_tail_q);
  assign lines_empty = (line_head_q == line_tail_q);

  assign start_move = accept && (in_i.opcode == OP_RX_BYTE) && !is_drop && is_eol &&
                      !ring_empty && !lines_full;
  assign start_read = accept && (in_i.opcode == OP_READ_LINE) && !lines_empty;

  // The move is over once the ring is drained and the last read has landed.
  assign move_done = (state_q == ST_MOVE) && ring_empty && !mv_v_q;
  assign read_last = ((CHAR_AW + 1)'({1'b0, cnt_q}) + (CHAR_AW + 1)'(1)) >=
                     (CHAR_AW + 1)'({1'b0, len_q});
  assign read_done = (state_q == ST_READ) && out_free && read_last;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_move) begin
          state_d = ST_MOVE;
        end else if (start_read) begin
          state_d = ST_READ;
        end
      end
      ST_MOVE: begin
        if (move_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        if (read_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control and register updates.
  always_comb begin
    char_head_d   = char_head_q;
    char_tail_d   = char_tail_q;
    line_head_d   = line_head_q;
    line_tail_d   = line_tail_q;
    slot_d        = slot_q;
    cnt_d         = cnt_q;
    len_d         = len_q;
    mv_v_d        = 1'b0;
    mv_idx_d      = mv_idx_q;
    ring_we       = 1'b0;
    ring_wa       = char_next(char_head_q);
    ring_re       = 1'b0;
    ring_ra       = char_next(char_tail_q);
    ls_we         = 1'b0;
    ls_wa         = ls_addr(slot_q, mv_idx_q);
    ls_re         = 1'b0;
    ls_ra         = ls_addr(slot_q, CHAR_AW'(cnt_q + CHAR_AW'(1)));
    len_we        = 1'b0;
    out_load      = 1'b0;
    out_char_d    = out_char_q;
    out_no_line_d = out_no_line_q;
    out_last_d    = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (accept && (in_i.opcode == OP_RX_BYTE) && !is_drop) begin
          if (is_eol) begin
            if (!ring_empty && lines_full) begin
              // No free slot: the pending line is thrown away.
              char_head_d = '0;
              char_tail_d = '0;
            end else if (!ring_empty) begin
              slot_d = new_slot;
              cnt_d  = '0;
            end
          end else if (char_next(char_head_q) != char_tail_q) begin
            ring_we     = 1'b1;
            char_head_d = char_next(char_head_q);
          end
        end else if (accept && (in_i.opcode == OP_READ_LINE)) begin
          if (lines_empty) begin
            out_load      = 1'b1;
            out_char_d    = '0;
            out_no_line_d = 1'b1;
            out_last_d    = 1'b1;
          end else begin
            slot_d = rd_slot;
            len_d  = line_length_q[rd_slot];
            cnt_d  = '0;
            ls_re  = 1'b1;
            ls_ra  = ls_addr(rd_slot, '0);
          end
        end
      end
      ST_MOVE: begin
        if (!ring_empty) begin
          char_tail_d = char_next(char_tail_q);
          ring_re     = 1'b1;
          mv_v_d      = 1'b1;
          mv_idx_d    = cnt_q;
          cnt_d       = CHAR_AW'(cnt_q + CHAR_AW'(1));
        end
        if (mv_v_q) begin
          ls_we = 1'b1;
        end
        if (move_done) begin
          len_we      = 1'b1;
          line_head_d = slot_q;
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_char_d    = ls_rd_q;
          out_no_line_d = 1'b0;
          out_last_d    = read_last;
          if (read_last) begin
            line_tail_d = slot_q;
          end else begin
            cnt_d = CHAR_AW'(cnt_q + CHAR_AW'(1));
            ls_re = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      char_head_q <= '0;
      char_tail_q <= '0;
      line_head_q <= '0;
      line_tail_q <= '0;
      mv_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      char_head_q <= char_head_d;
      char_tail_q <= char_tail_d;
      line_head_q <= line_head_d;
      line_tail_q <= line_tail_d;
      mv_v_q      <= mv_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q        <= slot_d;
    cnt_q         <= cnt_d;
    len_q         <= len_d;
    mv_idx_q      <= mv_idx_d;
    out_char_q    <= out_char_d;
    out_no_line_q <= out_no_line_d;
    out_last_q    <= out_last_d;
    if (len_we) begin
      line_length_q[slot_q] <= cnt_q;
    end
  end

  // Character ring: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      char_ring[ring_wa] <= in_i.rx_byte;
    end
    if (ring_re) begin
      ring_rd_q <= char_ring[ring_ra];
    end
  end

  // Line store: written during a move, read during a read request.
  always_ff @(posedge clk_i) begin
    if (ls_we) begin
      line_store[ls_wa] <= ring_rd_q;
    end
    if (ls_re) begin
      ls_rd_q <= line_store[ls_ra];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.line_char = out_char_q;
  assign out_o.no_line   = out_no_line_q;
  assign out_o.last      = out_last_q;

  // A byte is never written over the oldest pending character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_we |-> (ring_wa != char_tail_q))
    else $error("character ring overrun");

  // Closing a slot never makes the line ring look empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    move_done |=> (line_head_q != line_tail_q))
    else $error("line ring overrun");

  // The read walk stays inside the stored line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (cnt_q < len_q))
    else $error("read walk past end of line");

  // A result word is never loaded over one the sink has not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_o.ready))
    else $error("result word overwritten");

endmodule

`default_nettype wire

// ===== test/rx_line_assembler_fifo_test.sv =====
// Self-checking testbench for the receive line assembler: random line traffic against a predictor.
`timescale 1ns / 100ps

import rla_pkg::*;

// Tracks the line assembler's state from accepted input words and holds the
// result words that the block still owes, oldest first.
class line_scoreboard;
  typedef struct packed {
    logic [BYTE_W-1:0] line_char;
    logic              no_line;
    logic              last;
  } line_word_t;

  logic [BYTE_W-1:0]  pend_chars [CHAR_DEPTH];
  logic [CHAR_AW-1:0] pend_wr;
  logic [CHAR_AW-1:0] pend_rd;
  logic [BYTE_W-1:0]  lines [LINE_SLOTS][CHAR_DEPTH];
  int unsigned        line_len [LINE_SLOTS];
  logic [LINE_AW-1:0] line_wr;
  logic [LINE_AW-1:0] line_rd;
  line_word_t         awaited [$];
  int unsigned        mismatches;

  function new();
    pend_wr    = '0;
    pend_rd    = '0;
    line_wr    = '0;
    line_rd    = '0;
    mismatches = 0;
  endfunction

  function logic [CHAR_AW-1:0] char_after(logic [CHAR_AW-1:0] p);
    return (int'(p) == CHAR_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  function logic [LINE_AW-1:0] slot_after(logic [LINE_AW-1:0] p);
    return (int'(p) == LINE_SLOTS - 1) ? '0 : p + 1'b1;
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  task report(string msg);
    // Keep the log short if everything goes wrong; every mismatch still counts.
    if (mismatches < 40) $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Advance the predicted state by one accepted input word.
  function void note_word(logic op, logic [BYTE_W-1:0] b);
    logic [CHAR_AW-1:0] nxt;
    logic [LINE_AW-1:0] slot;
    line_word_t         w;
    int unsigned        n;

    if (op == OP_RX_BYTE) begin
      if (b == BYTE_NUL || b == BYTE_DEL) return;
      if (b == BYTE_CR || b == BYTE_LF) begin
        // An end of line with nothing pending is ignored.
        if (pend_wr == pend_rd) return;
        slot = slot_after(line_wr);
        if (slot == line_rd) begin
          // No free line slot: the pending characters are thrown away.
          pend_wr = '0;
          pend_rd = '0;
          return;
        end
        n = 0;
        while (pend_wr != pend_rd) begin
          pend_rd = char_after(pend_rd);
          lines[slot][n] = pend_chars[pend_rd];
          n++;
        end
        line_len[slot] = n;
        line_wr = slot;
        return;
      end
      nxt = char_after(pend_wr);
      if (nxt == pend_rd) return;  // character ring full, byte dropped
      pend_chars[nxt] = b;
      pend_wr = nxt;
    end else begin
      if (line_wr == line_rd) begin
        w.line_char = '0;
        w.no_line   = 1'b1;
        w.last      = 1'b1;
        awaited.push_back(w);
        return;
      end
      slot = slot_after(line_rd);
      n = line_len[slot];
      for (int i = 0; i < n; i++) begin
        w.line_char = lines[slot][i];
        w.no_line   = 1'b0;
        w.last      = (i == n - 1);
        awaited.push_back(w);
      end
      line_rd = slot;
    end
  endfunction

  // Compare one accepted result word with the oldest one still owed.
  task check_result(logic [BYTE_W-1:0] ch, logic nl, logic lst);
    line_word_t w;

    if (awaited.size() == 0) begin
      report($sformatf("result word char=%02h no_line=%0b last=%0b with none expected",
                       ch, nl, lst));
      return;
    end
    w = awaited.pop_front();
    if (ch !== w.line_char)
      report($sformatf("line_char %02h, expected %02h", ch, w.line_char));
    if (nl !== w.no_line)
      report($sformatf("no_line %0b, expected %0b", nl, w.no_line));
    if (lst !== w.last)
      report($sformatf("last %0b, expected %0b", lst, w.last));
  endtask
endclass

module rx_line_assembler_fifo_test;

  // Kinds of random sequence that the stimulus strings together.
  typedef enum {
    SEQ_LINE,
    SEQ_LONG_LINE,
    SEQ_READ,
    SEQ_READ_RUN,
    SEQ_EMPTY_EOL,
    SEQ_LINE_BURST,
    SEQ_NOISE
  } seq_kind_e;

  // Receiver stall patterns.
  typedef enum {
    RX_ALWAYS,
    RX_COIN,
    RX_MOSTLY,
    RX_PERIODIC
  } stall_mode_e;

  // The long hold-off of the receiver is much longer than any line walk, so
  // the block fills up and has to stall its input while a read is waiting.
  localparam int HOLD_CYCLES   = 400;
  // An end of line walks at most CHAR_DEPTH-1 characters, so
  // this many idle cycles at the end cover any work still in flight.
  localparam int TAIL_CYCLES   = CHAR_DEPTH + 16;
  localparam int RANDOM_WORDS  = 350;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rla_in_if  in_if ();
  rla_out_if out_if ();

  rx_line_assembler_fifo u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  line_scoreboard sb = new();

  int burst_left   = 0;
  int words_sent   = 0;
  bit hold_request = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Both channels are sampled at the rising edge, before any of the
  // nonblocking updates of that edge land. The result is checked first: a
  // result word taken at the same edge as a new read belongs to an older read.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.line_char, out_if.no_line, out_if.last);
      if (in_if.valid && in_if.ready)
        sb.note_word(in_if.opcode, in_if.rx_byte);
    end
  end

  // Offer one input word and return at the edge where it is taken. The sender
  // works in bursts; before each new burst it may sit idle for a while. A word
  // that follows straight on keeps valid high, so valid is never lowered and
  // raised within the same step.
  task automatic send_word(input logic op, input logic [BYTE_W-1:0] b);
    int gap;

    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid   <= 1'b1;
    in_if.opcode  <= op;
    in_if.rx_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    words_sent++;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    send_word(OP_RX_BYTE, b);
  endtask

  // The byte field is unused on a read, so it carries random junk.
  task automatic send_read();
    send_word(OP_READ_LINE, BYTE_W'($urandom_range(0, 255)));
  endtask

  function automatic logic [BYTE_W-1:0] pick_eol();
    return ($urandom_range(0, 1) == 1) ? BYTE_CR : BYTE_LF;
  endfunction

  // Any byte that ends up in the character ring.
  function automatic logic [BYTE_W-1:0] random_char();
    logic [BYTE_W-1:0] c;
    do c = BYTE_W'($urandom_range(1, 254)); while (c == BYTE_CR || c == BYTE_LF);
    return c;
  endfunction

  // A line of len characters, now and then with a dropped NUL or 0xFF mixed
  // in, closed by CR or LF.
  task automatic send_line(input int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_byte(($urandom_range(0, 1) == 1) ? BYTE_DEL : BYTE_NUL);
      send_byte(random_char());
    end
    send_byte(pick_eol());
  endtask

  // Stop offering words until the block has delivered everything it owes.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Receiver: changes its stall pattern after each random stretch, and once,
  // when asked, holds ready low for a long stretch that it counts itself.
  initial begin
    stall_mode_e mode;
    int          stretch;
    int          period;
    int          phase;

    mode    = RX_ALWAYS;
    stretch = 0;
    period  = 2;
    phase   = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        if (stretch == 0) begin
          mode    = stall_mode_e'($urandom_range(0, 3));
          stretch = $urandom_range(8, 60);
          period  = $urandom_range(2, 5);
          phase   = 0;
        end
        stretch--;
        case (mode)
          RX_ALWAYS: begin
            out_if.ready <= 1'b1;
          end
          RX_COIN: begin
            out_if.ready <= ($urandom_range(0, 1) == 1);
          end
          RX_MOSTLY: begin
            out_if.ready <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_if.ready <= (phase == 0);
            phase = (phase + 1) % period;
          end
        endcase
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    seq_kind_e kind;
    int        iter;
    int        r;
    int        random_end;
    bit        hold_done;
    bit        drain_done;

    iter       = 0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    in_if.valid   <= 1'b0;
    in_if.opcode  <= OP_RX_BYTE;
    in_if.rx_byte <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: dropped bytes, a read with no line, ends of line with
    // nothing pending, byte values at the edges of the kept range, a line of
    // one character, and more reads than there are lines.
    send_byte(BYTE_NUL);
    send_byte(BYTE_DEL);
    send_read();
    send_byte(BYTE_CR);
    send_byte(BYTE_LF);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'hFE);
    send_byte(BYTE_CR);
    send_byte(8'h55);
    send_byte(BYTE_NUL);
    send_byte(8'hAA);
    send_byte(BYTE_LF);
    send_byte(8'h41);
    send_byte(BYTE_CR);
    send_read();
    send_read();
    send_read();
    send_read();
    wait_drained();

    // Random part. Most of it is well-formed lines and reads; the first two
    // sequences make sure a line overruns the character ring and a burst of
    // lines overruns the line slots before anything else happens.
    random_end = words_sent + RANDOM_WORDS;
    while (words_sent < random_end) begin
      r = $urandom_range(0, 99);
      if (iter == 0)      kind = SEQ_LONG_LINE;
      else if (iter == 1) kind = SEQ_LINE_BURST;
      else if (r < 40)    kind = SEQ_LINE;
      else if (r < 44)    kind = SEQ_LONG_LINE;
      else if (r < 72)    kind = SEQ_READ;
      else if (r < 80)    kind = SEQ_READ_RUN;
      else if (r < 85)    kind = SEQ_EMPTY_EOL;
      else if (r < 90)    kind = SEQ_LINE_BURST;
      else                kind = SEQ_NOISE;
      iter++;

      case (kind)
        SEQ_LINE: begin
          send_line(($urandom_range(0, 99) < 85) ? $urandom_range(1, 8)
                                                 : $urandom_range(9, 20));
        end
        SEQ_LONG_LINE: begin
          // Anything past CHAR_DEPTH-1 characters is dropped by a full ring.
          // The very first long line is always too long for the ring.
          send_line((iter == 1) ? CHAR_DEPTH + 2
                                : $urandom_range(CHAR_DEPTH - 4, CHAR_DEPTH + 2));
        end
        SEQ_READ: begin
          send_read();
        end
        SEQ_READ_RUN: begin
          repeat ($urandom_range(2, 5)) send_read();
        end
        SEQ_EMPTY_EOL: begin
          send_byte(pick_eol());
        end
        SEQ_LINE_BURST: begin
          repeat ($urandom_range(LINE_SLOTS - 1, LINE_SLOTS + 2))
            send_line($urandom_range(1, 4));
        end
        default: begin
          // Any byte at all, which may leave a line half built for the next one.
          send_byte(BYTE_W'($urandom_range(0, 255)));
        end
      endcase

      // A third of the way in, the receiver holds off while lines and reads
      // keep coming, so a blocked read backs up into the input channel.
      if (!hold_done && words_sent > random_end - 2 * RANDOM_WORDS / 3) begin
        hold_done    = 1'b1;
        hold_request = 1'b1;
        repeat (3) begin
          send_line($urandom_range(3, 10));
          send_read();
        end
        send_read();
      end

      // Two thirds of the way in, the sender waits for every owed result.
      if (!drain_done && words_sent > random_end - RANDOM_WORDS / 3) begin
        drain_done = 1'b1;
        wait_drained();
      end
    end

    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, about 8 ms of simulated time.
  initial begin
    #(8_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule
